/* src/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked at the next edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

`endif

/* src/vca_pkg.sv */
package vca_pkg;

    localparam int MAX_CHANNELS = 24;
    localparam int MAX_VOICES   = 4;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAIL     = 2'd1;
    localparam logic [1:0] ST_BAD_TAG  = 2'd2;

    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_HELD = 2'd1;

    localparam logic [31:0] ID_STEP       = 32'h20;
    localparam logic [7:0]  STEAL_LIMIT   = 8'd101;
    localparam logic [31:0] SECONDARY_TAG = 32'hffff_ffff;

    localparam int unsigned TDATA_IN_W  = 136;
    localparam int unsigned TDATA_OUT_W = 72;

    // result kinds from the sequencer to the output register
    localparam logic [2:0] K_STOP  = 3'd0;
    localparam logic [2:0] K_FAIL  = 3'd1;
    localparam logic [2:0] K_OK    = 3'd2;
    localparam logic [2:0] K_FREE  = 3'd3;
    localparam logic [2:0] K_BAD   = 3'd4;
    localparam logic [2:0] K_FOUND = 3'd5;

    // datapath commands
    typedef struct packed {
        logic load;       // latch input item, step id counter on an allocation
        logic scan_start; // clear scan index / best
        logic scan_step;  // examine one channel
        logic steal;      // steal pass criteria
        logic pick;       // append best to chosen list
        logic commit_step;// process chosen[idx]
        logic rollback;   // free chosen[idx-1], idx--
        logic link_step;  // write tag/link for chosen[idx]
        logic do_free;
        logic idx_clr;
    } vca_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic got_full;   // got == need
        logic need_bad;
        logic idx_end;    // commit/link index == got
        logic idx_zero;
        logic victim;     // chosen[idx] held
        logic refused;    // chosen[idx] refuses
    } vca_sts_t;

endpackage

/* src/vca_datapath.sv */
module vca_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [4:0]           channel_count,
    input  logic [1:0]           in_command,
    input  logic [vca_pkg::MAX_CHANNELS-1:0] in_mask,
    input  logic [2:0]           in_need,
    input  logic [7:0]           in_prio,
    input  logic [4:0]           in_chan,
    input  logic [31:0]          in_tag,
    input  logic [31:0]          in_time,
    input  logic [vca_pkg::MAX_CHANNELS-1:0] in_refused,
    input  vca_pkg::vca_cmd_t    cmd,
    output vca_pkg::vca_sts_t    sts,
    output logic [31:0]          victim_tag,
    output logic [4:0]           primary,
    output logic [31:0]          new_tag,
    output logic                 lookup_ok,
    output logic [4:0]           lookup_ch,
    output logic [4:0]           free_ch
);
    import vca_pkg::*;

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int GW = $clog2(MAX_VOICES + 1);

    logic [31:0] owner_reg [MAX_CHANNELS];
    logic [1:0]  mode_reg  [MAX_CHANNELS];
    logic [7:0]  prio_reg  [MAX_CHANNELS];
    logic [31:0] time_reg  [MAX_CHANNELS];
    logic [4:0]  link_reg  [MAX_CHANNELS];
    logic [4:0]  chosen_reg [MAX_VOICES];
    logic [31:0] ctr_reg;

    logic [MAX_CHANNELS-1:0] mask_reg, refused_reg;
    logic [2:0]  need_reg;
    logic [7:0]  prio_in_reg;
    logic [4:0]  chan_reg;
    logic [31:0] tag_reg, time_in_reg;

    logic [CW-1:0] scan_reg;
    logic [GW-1:0] got_reg;
    logic [GW-1:0] idx_reg;
    logic          found_reg;
    logic [4:0]    best_reg;
    logic [7:0]    bp_reg;
    logic [31:0]   bt_reg;

    logic [CW-1:0] lim;
    logic [4:0]    cnt5;
    assign cnt5 = channel_count;
    assign lim = (32'(cnt5) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(cnt5);

    // candidate test on channel scan_reg
    logic [IW-1:0] sc;
    logic          in_chosen, cand, better;
    assign sc = scan_reg[IW-1:0];
    always_comb begin
        in_chosen = 1'b0;
        for (int i = 0; i < MAX_VOICES; i++) begin
            if (GW'(i) < got_reg && chosen_reg[i] == 5'(sc)) in_chosen = 1'b1;
        end
        cand = 1'b0;
        better = 1'b0;
        if (32'(scan_reg) < MAX_CHANNELS) begin
            if (cmd.steal) begin
                cand = mask_reg[5'(sc)] && !in_chosen && prio_reg[sc] < STEAL_LIMIT;
                better = !found_reg || prio_reg[sc] < bp_reg ||
                         (prio_reg[sc] == bp_reg && time_reg[sc] < bt_reg);
            end else begin
                cand = mask_reg[5'(sc)] && mode_reg[sc] == MODE_FREE && !in_chosen;
                better = !found_reg || time_reg[sc] < bt_reg;
            end
        end
    end

    // chosen entry at idx
    logic [VW-1:0] ix;
    logic [IW-1:0] cur;
    logic [IW-1:0] prv;
    assign ix  = idx_reg[VW-1:0];
    assign cur = chosen_reg[ix][IW-1:0];
    assign prv = chosen_reg[VW'(idx_reg - GW'(1))][IW-1:0];

    logic [IW-1:0] lk;
    assign lk = link_reg[cur][IW-1:0];
    always_comb begin
        victim_tag = owner_reg[cur];
        if (owner_reg[cur][31] && 32'(link_reg[cur]) < MAX_CHANNELS)
            victim_tag = owner_reg[lk];
    end

    assign primary = chosen_reg[0];
    assign new_tag = ctr_reg | {27'd0, chosen_reg[0]};

    logic [IW-1:0] lc;
    assign lookup_ch = tag_reg[4:0];
    assign lc = tag_reg[IW-1:0];
    assign lookup_ok = !tag_reg[31] && 32'(tag_reg[4:0]) < 32'(lim) &&
                       mode_reg[lc] != MODE_FREE && owner_reg[lc] == tag_reg;
    assign free_ch = chan_reg;

    assign sts.scan_done = scan_reg >= lim;
    assign sts.found     = found_reg;
    assign sts.got_full  = got_reg == GW'(need_reg);
    assign sts.need_bad  = need_reg == 3'd0 || 32'(need_reg) > MAX_VOICES;
    assign sts.idx_end   = idx_reg == got_reg;
    assign sts.idx_zero  = idx_reg == '0;
    assign sts.victim    = mode_reg[cur] == MODE_HELD;
    assign sts.refused   = refused_reg[5'(cur)];

    logic [31:0] ctr_step;
    assign ctr_step = ctr_reg + ID_STEP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
            got_reg <= '0;
            idx_reg <= '0;
            scan_reg <= '0;
            found_reg <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                owner_reg[c] <= '0;
                mode_reg[c]  <= MODE_FREE;
                prio_reg[c]  <= '0;
                time_reg[c]  <= '0;
                link_reg[c]  <= '0;
            end
        end else begin
            if (cmd.load) begin
                mask_reg    <= in_mask;
                refused_reg <= in_refused;
                need_reg    <= in_need;
                prio_in_reg <= in_prio;
                chan_reg    <= in_chan;
                tag_reg     <= in_tag;
                time_in_reg <= in_time;
                got_reg     <= '0;
                if (in_command == CMD_ALLOC) ctr_reg <= ctr_step[31] ? '0 : ctr_step;
            end
            if (cmd.scan_start) begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                scan_reg <= scan_reg + CW'(1);
                if (cand && better) begin
                    found_reg <= 1'b1;
                    best_reg  <= 5'(sc);
                    bp_reg    <= prio_reg[sc];
                    bt_reg    <= time_reg[sc];
                end
            end
            if (cmd.pick) begin
                chosen_reg[got_reg[VW-1:0]] <= best_reg;
                got_reg <= got_reg + GW'(1);
            end
            if (cmd.idx_clr) idx_reg <= '0;
            if (cmd.commit_step) begin
                mode_reg[cur] <= MODE_HELD;
                time_reg[cur] <= time_in_reg;
                prio_reg[cur] <= prio_in_reg;
                idx_reg <= idx_reg + GW'(1);
            end
            if (cmd.rollback) begin
                mode_reg[prv] <= MODE_FREE;
                idx_reg <= idx_reg - GW'(1);
            end
            if (cmd.link_step) begin
                if (idx_reg == '0) begin
                    owner_reg[cur] <= new_tag;
                end else begin
                    owner_reg[cur] <= SECONDARY_TAG;
                    link_reg[cur]  <= chosen_reg[0];
                end
                idx_reg <= idx_reg + GW'(1);
            end
            if (cmd.do_free && 32'(chan_reg) < MAX_CHANNELS) begin
                mode_reg[chan_reg[IW-1:0]] <= MODE_FREE;
                time_reg[chan_reg[IW-1:0]] <= time_in_reg;
            end
        end
    end
endmodule

/* src/vca_ctrl.sv */
module vca_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [1:0]        in_command,
    input  logic              out_free,
    input  vca_pkg::vca_sts_t sts,
    input  logic              lookup_ok,
    output vca_pkg::vca_cmd_t cmd,
    output logic              in_ready,
    output logic              emit,
    output logic [2:0]        emit_kind
);
    import vca_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_SCAN   = 11'b00000000100,
        S_PICK   = 11'b00000001000,
        S_COMMIT = 11'b00000010000,
        S_STOP   = 11'b00000100000,
        S_ROLL   = 11'b00001000000,
        S_LINK   = 11'b00010000000,
        S_FINAL  = 11'b00100000000,
        S_FREE   = 11'b01000000000,
        S_LOOK   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic steal_reg, steal_next;
    logic rolling_reg, rolling_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        steal_next = steal_reg;
        rolling_next = rolling_reg;
        cmd = '0;
        emit = 1'b0;
        emit_kind = K_OK;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    case (in_command)
                        CMD_ALLOC:  state_next = S_CHECK;
                        CMD_FREE:   state_next = S_FREE;
                        CMD_LOOKUP: state_next = S_LOOK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                if (sts.need_bad) begin
                    rolling_next = 1'b1;
                    state_next = S_FINAL;
                end else begin
                    rolling_next = 1'b0;
                    steal_next = 1'b0;
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.got_full) begin
                    cmd.idx_clr = 1'b1;
                    state_next = S_COMMIT;
                end else if (sts.scan_done) begin
                    state_next = S_PICK;
                end else begin
                    cmd.scan_step = 1'b1;
                    cmd.steal = steal_reg;
                end
            end
            S_PICK: begin
                cmd.scan_start = 1'b1;
                if (sts.found) begin
                    cmd.pick = 1'b1;
                    state_next = S_SCAN;
                end else if (!steal_reg) begin
                    steal_next = 1'b1;
                    state_next = S_SCAN;
                end else begin
                    rolling_next = 1'b1;
                    state_next = S_FINAL;
                end
            end
            S_COMMIT: begin
                if (sts.idx_end) begin
                    cmd.idx_clr = 1'b1;
                    state_next = S_LINK;
                end else if (sts.victim) begin
                    state_next = S_STOP;
                end else begin
                    cmd.commit_step = 1'b1;
                end
            end
            S_STOP: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_kind = K_STOP;
                    if (sts.refused) begin
                        rolling_next = 1'b1;
                        state_next = S_ROLL;
                    end else begin
                        cmd.commit_step = 1'b1;
                        state_next = S_COMMIT;
                    end
                end
            end
            S_ROLL: begin
                if (sts.idx_zero) state_next = S_FINAL;
                else cmd.rollback = 1'b1;
            end
            S_LINK: begin
                if (sts.idx_end) begin
                    rolling_next = 1'b0;
                    state_next = S_FINAL;
                end else begin
                    cmd.link_step = 1'b1;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_kind = rolling_reg ? K_FAIL : K_OK;
                    state_next = S_IDLE;
                end
            end
            S_FREE: begin
                if (out_free) begin
                    cmd.do_free = 1'b1;
                    emit = 1'b1;
                    emit_kind = K_FREE;
                    state_next = S_IDLE;
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_kind = lookup_ok ? K_FOUND : K_BAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            steal_reg <= 1'b0;
            rolling_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            steal_reg <= steal_next;
            rolling_reg <= rolling_next;
        end
    end
endmodule

/* src/voice_channel_allocator_core.sv */
// Voice channel allocator core.
// Input channel s_*: one command item per handshake. tdata packs command,
// eligible_mask, voices_needed, voice_priority, channel_index, lookup_tag,
// current_time and stop_refused_mask from bit 0 up.
// Result channel m_*: 0..5 items per input. An allocation emits one stop
// request per stolen held channel, then a final item with m_tlast high.
// Free and lookup give one item; command 3 gives none.
// Sequence: lookup and free go from the accept to their emit state, which writes
// the output register and returns to idle. An allocation runs a voice-count check,
// one pool scan per pick over min(channel_count, 24) channels, one more empty scan
// when it switches to the steal pass, a check that sees the list full, a commit
// step per chosen channel (with a stop request for a held one), a link step per
// channel and the emit of the final item.
// The scan loop sets the rate. One item at a time; s_tready is low while busy.
// Reset (aresetn low, synchronous) frees all channels, zeroes the table and
// the id counter and sets channel_count to 24.
// A stalled m_tready holds the output register; the sequencer waits in its
// emit state, adding the stall cycles, and no result is lost.
module voice_channel_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [25:2] eligible_mask, [28:26] voices_needed,
    // [36:29] voice_priority, [41:37] channel_index, [73:42] lookup_tag,
    // [105:74] current_time, [129:106] stop_refused_mask, rest zero
    input  logic [vca_pkg::TDATA_IN_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] stop_tag, [33:32] status, [38:34] result_channel,
    // [70:39] new_tag, rest zero
    output logic [vca_pkg::TDATA_OUT_W-1:0] m_tdata,
    // [0] is_stop_request
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vca_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] ADDR_COUNT = 3'd0;

    // config register
    logic [4:0] count_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_COUNT) ? {27'd0, count_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= 5'd24;
        else if (psel && penable && pwrite && paddr == ADDR_COUNT)
            count_reg <= pwdata[4:0];
    end

    vca_cmd_t cmd;
    vca_sts_t sts;
    logic [31:0] victim_tag, new_tag;
    logic [4:0]  primary, lookup_ch, free_ch;
    logic        lookup_ok, emit;
    logic [2:0]  emit_kind;
    logic        in_fire, out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    vca_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire,
        .in_command(s_tdata[1:0]),
        .out_free, .sts, .lookup_ok, .cmd,
        .in_ready(s_tready), .emit, .emit_kind
    );

    vca_datapath u_dp (
        .aclk, .aresetn,
        .channel_count(count_reg),
        .in_command(s_tdata[1:0]),
        .in_mask(s_tdata[25:2]),
        .in_need(s_tdata[28:26]),
        .in_prio(s_tdata[36:29]),
        .in_chan(s_tdata[41:37]),
        .in_tag(s_tdata[73:42]),
        .in_time(s_tdata[105:74]),
        .in_refused(s_tdata[129:106]),
        .cmd, .sts, .victim_tag, .primary, .new_tag,
        .lookup_ok, .lookup_ch, .free_ch
    );

    // output register
    logic        vld_reg;
    logic [31:0] stag_reg, ntag_reg;
    logic [1:0]  st_reg;
    logic [4:0]  ch_reg;
    logic        stop_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (emit) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            stop_reg <= 1'b0;
            stag_reg <= '0;
            st_reg   <= ST_OK;
            ch_reg   <= '0;
            ntag_reg <= '0;
            last_reg <= 1'b1;
            case (emit_kind)
                K_STOP: begin
                    stop_reg <= 1'b1;
                    stag_reg <= victim_tag;
                    last_reg <= 1'b0;
                end
                K_FAIL: st_reg <= ST_FAIL;
                K_OK: begin
                    ch_reg <= primary;
                    ntag_reg <= new_tag;
                end
                K_FREE: ch_reg <= free_ch;
                K_BAD: st_reg <= ST_BAD_TAG;
                K_FOUND: ch_reg <= lookup_ch;
                default: st_reg <= ST_OK;
            endcase
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = stop_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, ntag_reg, ch_reg, st_reg, stag_reg};

    `ASSERT_IMPL(a_emit_room, aclk, aresetn, emit, !m_tvalid || m_tready)
    `ASSERT_NEXT(a_busy_no_accept, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tlast, m_tdata}))
    `ASSERT_ALWAYS(a_stop_not_last, aclk, aresetn, !(m_tvalid && m_tuser && m_tlast))
endmodule

/* verif/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vca_pkg::*;

    localparam int NUM_CH        = 24;
    localparam int NUM_VOICES    = 4;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [1:0] CMD_NOP = 2'd3;

    // one request item, fields at block widths
    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] mask;
        logic [2:0]  need;
        logic [7:0]  prio;
        logic [4:0]  idx;
        logic [31:0] tag;
        logic [31:0] now;
        logic [23:0] refused;
    } voice_req_t;

    // one result item
    typedef struct packed {
        logic        stop;
        logic [31:0] stop_tag;
        logic [1:0]  status;
        logic [4:0]  chan;
        logic [31:0] new_tag;
        logic        last;
    } voice_res_t;

    // directed row: request plus an optional hand-written result
    typedef struct packed {
        voice_req_t req;
        logic       typed;
        voice_res_t res;
    } voice_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    voice_channel_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the channel table
    // ------------------------------------------------------------------
    logic [4:0]  pool_size;
    logic [31:0] sh_owner [NUM_CH];
    logic [1:0]  sh_mode  [NUM_CH];
    logic [7:0]  sh_prio  [NUM_CH];
    logic [31:0] sh_time  [NUM_CH];
    logic [4:0]  sh_link  [NUM_CH];
    logic [31:0] id_counter;

    voice_res_t  pending_q[$];   // results still owed by the block
    logic [31:0] live_tags[$];   // tags handed out, used to build lookups

    int n_items, n_results, n_stops, n_alloc_ok, n_mismatch;
    int burst_left;
    bit long_hold;

    function automatic voice_res_t mk_res(logic stop, logic [31:0] stag, logic [1:0] st,
                                          logic [4:0] ch, logic [31:0] ntag, logic last);
        voice_res_t r;
        r.stop = stop; r.stop_tag = stag; r.status = st;
        r.chan = ch; r.new_tag = ntag; r.last = last;
        return r;
    endfunction

    // Allocation: free pass (oldest eligible free), then steal pass
    // (lowest priority under the limit, then oldest); ties keep low index.
    task automatic predict_alloc(input voice_req_t rq);
        logic [4:0]  picks [NUM_VOICES];
        logic [23:0] taken;
        int lim, got, best, i, j;
        bit found;
        logic [31:0] bt, owner, ntag;
        logic [7:0]  bp;
        logic [4:0]  ch, primary;
        id_counter = id_counter + ID_STEP;
        if (id_counter[31]) id_counter = '0;
        if (rq.need == 0 || rq.need > NUM_VOICES) begin
            pending_q.push_back(mk_res(1'b0, 32'd0, ST_FAIL, 5'd0, 32'd0, 1'b1));
            return;
        end
        lim = (pool_size > NUM_CH) ? NUM_CH : int'(pool_size);
        taken = '0;
        got = 0;
        while (got < rq.need) begin
            found = 0; best = 0; bt = '0;
            for (int c = 0; c < lim; c++) begin
                if (!rq.mask[c] || sh_mode[c] != MODE_FREE || taken[c]) continue;
                if (!found || sh_time[c] < bt) begin
                    found = 1; bt = sh_time[c]; best = c;
                end
            end
            if (!found) break;
            picks[got] = best[4:0]; taken[best] = 1'b1; got++;
        end
        while (got < rq.need) begin
            found = 0; best = 0; bt = '0; bp = '0;
            for (int c = 0; c < lim; c++) begin
                if (!rq.mask[c] || taken[c] || sh_prio[c] >= STEAL_LIMIT) continue;
                if (!found || sh_prio[c] < bp || (sh_prio[c] == bp && sh_time[c] < bt)) begin
                    found = 1; bp = sh_prio[c]; bt = sh_time[c]; best = c;
                end
            end
            if (!found) break;
            picks[got] = best[4:0]; taken[best] = 1'b1; got++;
        end
        if (got != rq.need) begin
            pending_q.push_back(mk_res(1'b0, 32'd0, ST_FAIL, 5'd0, 32'd0, 1'b1));
            return;
        end
        primary = picks[0];
        ntag = id_counter | {27'd0, primary};
        for (i = 0; i < got; i++) begin
            ch = picks[i];
            if (sh_mode[ch] == MODE_HELD) begin
                owner = sh_owner[ch];
                // secondary: stop the sound that owns its primary
                if (owner[31] && sh_link[ch] < NUM_CH) owner = sh_owner[sh_link[ch]];
                pending_q.push_back(mk_res(1'b1, owner, ST_OK, 5'd0, 32'd0, 1'b0));
                if (rq.refused[ch]) begin
                    for (j = 0; j < i; j++) sh_mode[picks[j]] = MODE_FREE;
                    pending_q.push_back(mk_res(1'b0, 32'd0, ST_FAIL, 5'd0, 32'd0, 1'b1));
                    return;
                end
            end
            sh_mode[ch] = MODE_HELD;
            sh_time[ch] = rq.now;
            sh_prio[ch] = rq.prio;
        end
        sh_owner[primary] = ntag;
        for (i = 1; i < got; i++) begin
            sh_owner[picks[i]] = SECONDARY_TAG;
            sh_link[picks[i]] = primary;
        end
        pending_q.push_back(mk_res(1'b0, 32'd0, ST_OK, primary, ntag, 1'b1));
        live_tags.push_back(ntag);
        if (live_tags.size() > 16) void'(live_tags.pop_front());
    endtask

    task automatic predict_item(input voice_req_t rq);
        logic [4:0] ch;
        int lim;
        case (rq.cmd)
            CMD_ALLOC: predict_alloc(rq);
            CMD_FREE: begin
                if (rq.idx < NUM_CH) begin
                    sh_mode[rq.idx] = MODE_FREE;
                    sh_time[rq.idx] = rq.now;
                end
                pending_q.push_back(mk_res(1'b0, 32'd0, ST_OK, rq.idx, 32'd0, 1'b1));
            end
            CMD_LOOKUP: begin
                ch = rq.tag[4:0];
                lim = (pool_size > NUM_CH) ? NUM_CH : int'(pool_size);
                if (rq.tag[31] || ch >= lim || sh_mode[ch] == MODE_FREE ||
                    sh_owner[ch] != rq.tag)
                    pending_q.push_back(mk_res(1'b0, 32'd0, ST_BAD_TAG, 5'd0, 32'd0, 1'b1));
                else
                    pending_q.push_back(mk_res(1'b0, 32'd0, ST_OK, ch, 32'd0, 1'b1));
            end
            default: ;  // unused command: nothing comes back
        endcase
    endtask

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no traffic for %0d cycles, %0d results owed",
                         IDLE_LIMIT, pending_q.size());
                $display("** voice_channel_allocator_core: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        voice_res_t got_r, want;
        if (aresetn && m_tvalid && m_tready) begin
            got_r = mk_res(m_tuser, m_tdata[31:0], m_tdata[33:32], m_tdata[38:34],
                           m_tdata[70:39], m_tlast);
            n_results++;
            if (got_r.stop) n_stops++;
            if (pending_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected item: stop=%0b tag=%h st=%0d ch=%0d ntag=%h last=%0b",
                             got_r.stop, got_r.stop_tag, got_r.status, got_r.chan,
                             got_r.new_tag, got_r.last);
            end else begin
                want = pending_q.pop_front();
                if (got_r !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp stop=%0b tag=%h st=%0d ch=%0d ntag=%h ",
                                  "last=%0b / got stop=%0b tag=%h st=%0d ch=%0d ntag=%h last=%0b"},
                                 want.stop, want.stop_tag, want.status, want.chan,
                                 want.new_tag, want.last, got_r.stop, got_r.stop_tag,
                                 got_r.status, got_r.chan, got_r.new_tag, got_r.last);
                end else if (!want.stop && want.status == ST_OK && want.new_tag != 0) begin
                    n_alloc_ok++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a random mix of ready runs and choppy stretches, plus one
    // long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int run_len;
        bit choppy;
        m_tready = 1'b0;
        forever begin
            if (long_hold) begin
                repeat (400) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
                long_hold = 0;
            end
            run_len = $urandom_range(5, 60);
            choppy  = $urandom_range(0, 2) != 0;
            repeat (run_len) begin
                @(posedge aclk);
                m_tready <= choppy ? ($urandom_range(0, 99) < 55) : 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic drain_results();
        while (pending_q.size() != 0) @(posedge aclk);
        // a no-result item may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; pready is tied high
    task automatic write_pool_size(input logic [4:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_CHANNEL_COUNT; pwdata <= {27'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pool_size = val;
    endtask

    // Offer one item and hold it until taken; bursts end in random gaps.
    task automatic send_req(input voice_req_t rq, input bit typed, input voice_res_t res);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rq.refused, rq.now, rq.tag, rq.idx, rq.prio, rq.need,
                    rq.mask, rq.cmd};
        do @(posedge aclk); while (!s_tready);
        predict_item(rq);
        if (typed) begin
            void'(pending_q.pop_back());
            pending_q.push_back(res);
        end
        n_items++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    logic [31:0] note_clock;

    function automatic voice_req_t random_req();
        voice_req_t rq;
        int pick;
        logic [31:0] r1, r2;
        rq.cmd = CMD_ALLOC;
        r1 = $urandom;
        rq.mask = r1[23:0]; rq.need = 3'd1;
        r1 = $urandom;
        rq.prio = r1[7:0]; rq.idx = r1[12:8];
        rq.tag = $urandom; rq.refused = '0;
        note_clock = note_clock + $urandom_range(1, 50);
        rq.now = ($urandom_range(0, 4) == 0) ? $urandom : note_clock;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            rq.cmd = CMD_ALLOC;
            r1 = $urandom; r2 = $urandom;
            case ($urandom_range(0, 3))
                0, 1: rq.mask = 24'hffffff;
                2:    rq.mask = r1[23:0] | r2[23:0];
                default: rq.mask = r1[23:0] & r2[23:0];
            endcase
            rq.need = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 8) & 7)
                                                  : 3'($urandom_range(1, 4));
            if ($urandom_range(0, 1)) rq.prio = 8'($urandom_range(0, 100));
            r1 = $urandom; r2 = $urandom;
            if ($urandom_range(0, 9) < 3) rq.refused = r1[23:0] & r2[23:0];
        end else if (pick < 72) begin
            rq.cmd = CMD_FREE;
            rq.idx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                                 : 5'($urandom_range(0, 23));
        end else if (pick < 95) begin
            rq.cmd = CMD_LOOKUP;
            if (live_tags.size() != 0 && $urandom_range(0, 9) < 7) begin
                rq.tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
                // sometimes a near miss
                if ($urandom_range(0, 4) == 0) rq.tag[$urandom_range(0, 31)] ^= 1'b1;
            end
        end else begin
            rq.cmd = CMD_NOP;
        end
        return rq;
    endfunction

    function automatic voice_row_t row(logic [1:0] cmd, logic [23:0] mask, logic [2:0] need,
                                       logic [7:0] prio, logic [4:0] idx, logic [31:0] tag,
                                       logic [31:0] now, logic [23:0] refused,
                                       logic typed, logic [1:0] st, logic [4:0] ch);
        voice_row_t r;
        r.req = '{cmd, mask, need, prio, idx, tag, now, refused};
        r.typed = typed;
        r.res = mk_res(1'b0, 32'd0, st, ch, 32'd0, 1'b1);
        return r;
    endfunction

    // Directed rows. Typed results are the ones that follow from the table
    // right after reset; the rest go through the shadow model.
    voice_row_t directed [$];

    initial begin
        logic [4:0] sizes [5];
        aresetn  = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        long_hold = 0; burst_left = 3; note_clock = 32'd1000;
        n_items = 0; n_results = 0; n_stops = 0; n_alloc_ok = 0; n_mismatch = 0;
        pool_size = 5'd24; id_counter = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            sh_owner[c] = '0; sh_mode[c] = MODE_FREE; sh_prio[c] = '0;
            sh_time[c] = '0; sh_link[c] = '0;
        end
        sizes = '{5'd0, 5'd31, 5'd5, 5'd1, 5'd24};

        // empty table: every tag is unknown
        directed.push_back(row(CMD_LOOKUP, 0, 1, 0, 0, 32'h0, 0, 0, 1, ST_BAD_TAG, 0));
        directed.push_back(row(CMD_LOOKUP, 0, 1, 0, 0, 32'h8000_0000, 0, 0, 1, ST_BAD_TAG, 0));
        directed.push_back(row(CMD_LOOKUP, 0, 1, 0, 0, 32'hffff_ffff, 0, 0, 1, ST_BAD_TAG, 0));
        // free echoes the index; one outside the pool touches nothing
        directed.push_back(row(CMD_FREE, 0, 1, 0, 31, 0, 32'hffff_ffff, 0, 1, ST_OK, 31));
        directed.push_back(row(CMD_FREE, 0, 1, 0, 23, 0, 32'hffff_ffff, 0, 1, ST_OK, 23));
        // bad voice counts and an empty mask fail
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 0, 0, 0, 0, 5, 0, 1, ST_FAIL, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 5, 0, 0, 0, 5, 0, 1, ST_FAIL, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 7, 0, 0, 0, 5, 0, 1, ST_FAIL, 0));
        directed.push_back(row(CMD_ALLOC, 24'h000000, 1, 0, 0, 0, 5, 0, 1, ST_FAIL, 0));
        // fill three groups from free channels
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 4, 8'd50,  0, 0, 10, 0, 0, 0, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 4, 8'd255, 0, 0, 20, 0, 0, 0, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 4, 8'd0,   0, 0, 30, 0, 0, 0, 0));
        directed.push_back(row(CMD_LOOKUP, 0, 1, 0, 0, 32'h0000_00a0, 0, 0, 0, 0, 0));
        // steal from the priority 50 group: secondary owner goes to its primary
        directed.push_back(row(CMD_ALLOC, 24'h00000e, 2, 8'd100, 0, 0, 40, 0, 0, 0, 0));
        directed.push_back(row(CMD_LOOKUP, 0, 1, 0, 0, 32'h0000_00a0, 0, 0, 0, 0, 0));
        // priority 255 group cannot be stolen
        directed.push_back(row(CMD_ALLOC, 24'h0000f0, 1, 8'd1, 0, 0, 45, 0, 0, 0, 0));
        // steal with a refusal on the second victim: rollback
        directed.push_back(row(CMD_ALLOC, 24'h000f00, 2, 8'd7, 0, 0, 50, 24'h000200,
                               0, 0, 0));
        directed.push_back(row(CMD_FREE, 0, 1, 0, 0, 0, 60, 0, 0, 0, 0));
        directed.push_back(row(CMD_ALLOC, 24'h000001, 1, 8'd101, 0, 0, 70, 0, 0, 0, 0));
        directed.push_back(row(CMD_NOP, 24'hffffff, 4, 8'hff, 5'h1f, 32'hffff_ffff,
                               32'hffff_ffff, 24'hffffff, 0, 0, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 4, 8'd101, 0, 0, 32'hffff_fff0,
                               24'hffffff, 0, 0, 0));
        directed.push_back(row(CMD_ALLOC, 24'hffffff, 4, 8'd100, 0, 0, 80, 24'h800000, 0, 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].res);
        s_tvalid <= 1'b0;
        drain_results();

        // one phase per pool size, extremes included; the last restores 24
        foreach (sizes[p]) begin
            write_pool_size(sizes[p]);
            repeat ((sizes[p] < 2) ? 10 : 34) begin
                send_req(random_req(), 0, '0);
                // long receiver hold-off while items keep coming
                if (p == 2 && n_items % 34 == 0) long_hold = 1;
            end
            s_tvalid <= 1'b0;
            drain_results();
        end

        // random traffic at full pool, with a full pause in the middle
        repeat (15) send_req(random_req(), 0, '0);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (15) send_req(random_req(), 0, '0);
        s_tvalid <= 1'b0;
        drain_results();

        $display("covered %0d items, %0d results (%0d stop requests, %0d allocations granted)",
                 n_items, n_results, n_stops, n_alloc_ok);
        $display("pool sizes 24, 0, 31, 5, 1; %0d mismatches", n_mismatch);
        if (n_mismatch == 0) begin
            $display("** voice_channel_allocator_core: PASSED **");
        end else begin
            $display("** voice_channel_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/vca_pkg.sv
src/vca_datapath.sv
src/vca_ctrl.sv
src/voice_channel_allocator_core.sv
verif/testbench.sv
